[hw/rtl/sbbf_pkg.sv]
// sbbf_pkg: shared constants, salt table and probe helper for the split block
// bloom filter. no dependencies.
package sbbf_pkg;

  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int WORDS          = 8;
  localparam int WORD_W         = 32;
  localparam int BLOCK_W        = WORDS * WORD_W;
  localparam int HALF_W         = 32;
  localparam int HASH_W         = 2 * HALF_W;
  localparam int SEL_SHIFT      = 27;
  localparam int POS_W          = 5;
  localparam int CNT_W          = 11;
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_FIND   = 1'b1;

  localparam logic [WORD_W-1:0] SALT [WORDS] = '{
    32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
    32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
  };

  // bit position inside word w, top bits of the low half of key * salt
  function automatic logic [POS_W-1:0] probe_pos(input logic [WORD_W-1:0] key,
                                                 input logic [2:0] w);
    logic [WORD_W-1:0] prod;
    prod = key * SALT[w];
    return prod[SEL_SHIFT +: POS_W];
  endfunction

endpackage

[hw/rtl/sbbf_ram.sv]
// sbbf_ram: generic simple dual port ram, one write and one registered read.
// no dependencies.
module sbbf_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/split_block_bloom_filter.sv]
// split_block_bloom_filter: top level, insert and find of 64-bit hashes.
// depends on sbbf_pkg and sbbf_ram.
// steps from input request to result register: calc, read, modify.
// no new input request is taken until the previous one has left the modify state.
// a waiting result does not block the next input request; a find holds in modify
// until the previous result is taken.
// reset: synchronous active low; then a clearing pass over all MAX_BLOCKS blocks zeroes
// the store, no input request taken meanwhile; blocks_in_use resets to 1024.
module split_block_bloom_filter #(
  parameter int MAX_BLOCKS = sbbf_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [sbbf_pkg::CNT_W-1:0]  cfg_wr_data,   // blocks_in_use
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sbbf_pkg::HASH_W-1:0] in_tdata,      // [63:0] hash_value
  input  logic                        in_tuser,      // [0] action
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata      // [0] hit, [7:1] zero
);
  import sbbf_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_MOD   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                act_r;
  logic [HASH_W-1:0]   hash_r;
  logic [AW-1:0]       blk_r;
  logic [POS_W-1:0]    pos_r [WORDS];
  logic                out_valid_r, out_valid_nxt;
  logic                hit_r;

  logic [CNT_W-1:0]        n_eff;
  logic [HALF_W+CNT_W-1:0] blk_prod;
  logic [BLOCK_W-1:0]      mask;
  logic [BLOCK_W-1:0]      rd_data;
  logic [WORDS-1:0]        word_hit;
  logic                    out_free;
  logic                    ram_we;
  logic [AW-1:0]           ram_wr_addr;
  logic [BLOCK_W-1:0]      ram_wr_data;

  // a count of zero acts as one, above capacity acts as capacity
  always_comb begin
    n_eff = cnt_r;
    if (cnt_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cnt_r) > 32'(MAX_BLOCKS)) begin
      n_eff = CNT_W'(MAX_BLOCKS);
    end
  end

  assign blk_prod = (HALF_W+CNT_W)'(hash_r[HASH_W-1:HALF_W]) * (HALF_W+CNT_W)'(n_eff);

  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      mask[w*WORD_W +: WORD_W] = WORD_W'(1) << pos_r[w];
      word_hit[w] = |(rd_data[w*WORD_W +: WORD_W] & mask[w*WORD_W +: WORD_W]);
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_wr_addr   = blk_r;
    ram_wr_data   = rd_data | mask;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_wr_addr = clr_r;
        ram_wr_data = '0;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(MAX_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MOD;
      ST_MOD: begin
        if (act_r == ACT_INSERT) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= CNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= in_tuser;
      hash_r <= in_tdata;
    end
    if (state_r == ST_CALC) begin
      blk_r <= AW'(32'(blk_prod[HALF_W +: CNT_W]));
      for (int w = 0; w < WORDS; w++) begin
        pos_r[w] <= probe_pos(hash_r[HALF_W-1:0], 3'(w));
      end
    end
    if (state_r == ST_MOD && act_r == ACT_FIND && out_free) begin
      hit_r <= &word_hit;
    end
  end

  sbbf_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (state_r == ST_READ),
    .rd_addr (blk_r),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, hit_r};

endmodule

[verif/tb_split_block_bloom_filter.sv]
// tb_split_block_bloom_filter: self-checking testbench for the split block bloom filter,
// predicting every find result from its own copy of the block store and the block count.
// depends on sbbf_pkg and the split_block_bloom_filter rtl.
`timescale 1ns / 1ps

module tb_split_block_bloom_filter;
  import sbbf_pkg::*;

  localparam int NUM_BLOCKS    = MAX_BLOCKS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 4000;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [HASH_W-1:0] in_tdata = '0;   // [63:0] hash_value
  logic              in_tuser = ACT_INSERT;   // [0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // [0] hit, [7:1] zero

  // predictor state
  logic [WORD_W-1:0] bloom_store [NUM_BLOCKS][WORDS];
  logic [CNT_W-1:0]  block_count;
  logic              pending_hits [$];
  logic [HASH_W-1:0] inserted_keys [$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  logic        want_hit;

  split_block_bloom_filter #(
    .MAX_BLOCKS(NUM_BLOCKS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] probe_bit(input logic [WORD_W-1:0] key, input int w);
    logic [WORD_W-1:0] prod;
    prod = key * SALT[w];
    return 32'd1 << (prod >> SEL_SHIFT);
  endfunction

  function automatic int unsigned block_index(input logic [HASH_W-1:0] hash);
    logic [63:0] n;
    logic [63:0] prod;
    if (block_count == '0) begin
      n = 64'd1;
    end else if (32'(block_count) > NUM_BLOCKS) begin
      n = 64'(NUM_BLOCKS);
    end else begin
      n = 64'(block_count);
    end
    prod = {32'd0, hash[63:32]} * n;
    if (prod[63:32] >= n) return 32'(n - 64'd1);
    return prod[63:32];
  endfunction

  task automatic apply_to_store(input logic act, input logic [HASH_W-1:0] hash);
    int unsigned blk;
    logic all_set;
    blk = block_index(hash);
    all_set = 1'b1;
    for (int w = 0; w < WORDS; w++) begin
      if (act == ACT_INSERT) begin
        bloom_store[blk][w] |= probe_bit(hash[31:0], w);
      end else if ((bloom_store[blk][w] & probe_bit(hash[31:0], w)) == '0) begin
        all_set = 1'b0;
      end
    end
    if (act == ACT_FIND) pending_hits.push_back(all_set);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // one request; valid stays high into the next request unless a gap is drawn
  task automatic send_request(input logic act, input logic [HASH_W-1:0] hash);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= hash;
    in_tuser  <= act;
    do @(posedge clk); while (in_tready !== 1'b1);
    apply_to_store(act, hash);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 31);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // inserts give no result, so let the pipeline drain after the last find
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [CNT_W-1:0] count);
    wait_for_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    block_count = count;
  endtask

  // extremes of the hash at the reset block count
  task automatic test_reset_state();
    send_request(ACT_FIND,   64'h0000000000000000);
    send_request(ACT_INSERT, 64'h0000000000000000);
    send_request(ACT_FIND,   64'h0000000000000000);
    send_request(ACT_FIND,   64'hFFFFFFFFFFFFFFFF);
    send_request(ACT_INSERT, 64'hFFFFFFFFFFFFFFFF);
    send_request(ACT_FIND,   64'hFFFFFFFFFFFFFFFF);
    send_request(ACT_INSERT, 64'hFFFFFFFF00000000);
    send_request(ACT_FIND,   64'h00000000FFFFFFFF);
    send_request(ACT_INSERT, 64'hAAAAAAAA55555555);
    send_request(ACT_FIND,   64'h55555555AAAAAAAA);
    send_request(ACT_FIND,   64'hAAAAAAAA55555555);
  endtask

  // a zero count behaves as one block, over the old contents
  task automatic test_zero_count();
    write_block_count(11'd0);
    send_request(ACT_INSERT, 64'h123456789ABCDEF0);
    send_request(ACT_FIND,   64'hFFFFFFFF9ABCDEF0);
    send_request(ACT_FIND,   64'h8000000000000001);
  endtask

  // counts above capacity clamp to the store size
  task automatic test_over_capacity();
    write_block_count(11'd2047);
    send_request(ACT_INSERT, 64'hFFFFFFFF13579BDF);
    send_request(ACT_FIND,   64'hFFFFFFFF13579BDF);
    send_request(ACT_FIND,   64'h0000000013579BDF);
    write_block_count(11'd1025);
    send_request(ACT_FIND,   64'hFFFFFFFF13579BDF);
    write_block_count(11'd1);
    send_request(ACT_FIND,   64'hFFFFFFFF00000000);
  endtask

  // mixed inserts and finds, store kept across count changes
  task automatic test_random_traffic();
    logic [CNT_W-1:0]  count;
    logic [HASH_W-1:0] hash;
    int unsigned       roll;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: count = 11'd1;
        1: count = 11'd2;
        2: count = 11'd1024;
        3: count = 11'd0;
        4: count = 11'd2047;
        5: count = CNT_W'($urandom_range(3, 1023));
        6: count = CNT_W'($urandom_range(1025, 2047));
        default: count = CNT_W'($urandom_range(3, 1023));
      endcase
      write_block_count(count);
      for (int k = 0; k < 100; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45 || inserted_keys.size() == 0) begin
          hash = {$urandom, $urandom};
          inserted_keys.push_back(hash);
          if (inserted_keys.size() > 200) void'(inserted_keys.pop_front());
          send_request(ACT_INSERT, hash);
        end else begin
          hash = (roll < 90) ? inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]
                             : {$urandom, $urandom};
          // near misses: a known key with one bit flipped
          if (roll >= 75 && roll < 90) hash ^= 64'd1 << $urandom_range(0, 63);
          send_request(ACT_FIND, hash);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= ~out_tready;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result with no find outstanding");
      end else begin
        want_hit = pending_hits.pop_front();
        if (out_tdata[0] !== want_hit)
          report_mismatch($sformatf("hit %b, expected %b", out_tdata[0], want_hit));
        if (out_tdata[7:1] !== 7'd0)
          report_mismatch($sformatf("padding bits %b, expected zero", out_tdata[7:1]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (bloom_store[b, w]) bloom_store[b][w] = '0;
    block_count = CNT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_zero_count();
    test_over_capacity();
    test_random_traffic();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sbbf_pkg.sv
hw/rtl/sbbf_ram.sv
hw/rtl/split_block_bloom_filter.sv
verif/tb_split_block_bloom_filter.sv
